// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request classes, queued command word, register indexes, field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int QDEPTH      = 2;

  localparam int IDX_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'h0A;
  localparam logic                 REQ_PUT      = 1'b0;
  localparam logic                 REQ_READ     = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_FG       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG       = 2'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd2;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_NEWLINE   = 2'd1,
    OP_READ      = 2'd2,
    OP_READ_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    logic              last;
  } cmd_t;

endpackage

// ----- hdl/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console, ROWS x COLUMNS cells
// Throughput: one command per cycle from the queue while the back end is idle;
//   a cell read, a scroll (row-up copy, last-row clear, put) and the clear pass
//   after reset hold the queue.
// Reset: busy stays high while the memory is cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]     in_cell_index,
  input  logic                          in_last_in_write,
  output logic                          out_strobe,
  output logic [tcw_pkg::IDX_W-1:0]     out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]    out_read_char,
  output logic [tcw_pkg::ATTR_W-1:0]    out_read_attr,
  output logic                          out_scrolled,
  output logic                          out_write_done,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic               clearing;
  logic               pop;
  logic               head_vld;
  cmd_t               head;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FG:  fg_nxt = cfg_wdata;
        REG_BG:  bg_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_char_code     (in_char_code),
    .in_cell_index    (in_cell_index),
    .in_last_in_write (in_last_in_write),
    .clearing         (clearing),
    .pop              (pop),
    .head_vld         (head_vld),
    .head             (head)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head           (head),
    .attr           ({bg_r, fg_r}),
    .pop            (pop),
    .clearing       (clearing),
    .out_strobe     (out_strobe),
    .out_cursor_pos (out_cursor_pos),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr),
    .out_scrolled   (out_scrolled),
    .out_write_done (out_write_done)
  );

endmodule

// ----- hdl/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front: request intake
// Takes requests, sorts them into put, newline, cell read and out-of-screen
// read, and holds them in a short command queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]   in_cell_index,
  input  logic                        in_last_in_write,
  input  logic                        clearing,
  input  logic                        pop,
  output logic                        head_vld,
  output tcw_pkg::cmd_t               head
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int W_IDX = $clog2(CELLS + 1);
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t                         q_mem [QDEPTH];
  logic [PTR_W-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         full;
  logic                         push;
  logic                         do_pop;
  logic [W_IDX+IDX_W-1:0]       cell_ext;
  logic                         in_range;
  cmd_t                         cmd;

  assign full     = (cnt_r == CNT_W'(QDEPTH));
  assign busy     = full | clearing;
  assign push     = start & ~busy;
  assign head_vld = (cnt_r != '0);
  assign do_pop   = pop & head_vld;
  assign head     = q_mem[rd_ptr_r];

  assign cell_ext = {{W_IDX{1'b0}}, in_cell_index};
  assign in_range = (cell_ext < CELLS);

  always_comb begin
    cmd.char_code  = in_char_code;
    cmd.cell_index = in_cell_index;
    cmd.last       = in_last_in_write;
    if (in_req_type == REQ_READ) begin
      cmd.op = in_range ? OP_READ : OP_READ_NONE;
    end else begin
      cmd.op = (in_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
    end
  end

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ----- hdl/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back: command execution and screen memory
// Owns the cell memory, write index and cursor; runs the clear pass, cell
// reads, newlines, puts and the row-up scroll copy.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_vld,
  input  tcw_pkg::cmd_t               head,
  input  logic [tcw_pkg::ATTR_W-1:0]  attr,
  output logic                        pop,
  output logic                        clearing,
  output logic                        out_strobe,
  output logic [tcw_pkg::IDX_W-1:0]   out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]  out_read_char,
  output logic [tcw_pkg::ATTR_W-1:0]  out_read_attr,
  output logic                        out_scrolled,
  output logic                        out_write_done
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int W_ADR = $clog2(CELLS);
  localparam int W_IDX = $clog2(CELLS + 1);
  localparam int W_COL = $clog2(COLUMNS);
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [W_ADR-1:0] LAST_A  = W_ADR'(CELLS - 1);
  localparam logic [W_ADR-1:0] SHIFT_A = W_ADR'(CELLS - COLUMNS);
  localparam logic [W_ADR-1:0] COLS_A  = W_ADR'(COLUMNS);
  localparam logic [W_IDX-1:0] CELLS_I = W_IDX'(CELLS);
  localparam logic [W_IDX-1:0] COLS_I  = W_IDX'(COLUMNS);
  localparam logic [W_IDX-1:0] SPUT_I  = W_IDX'(CELLS - COLUMNS + 1);
  localparam logic [W_COL-1:0] COL_MAX = W_COL'(COLUMNS - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_SCLR   = 6'b010000,
    S_SPUT   = 6'b100000
  } state_t;

  logic [CELL_W-1:0] mem [CELLS];

  state_t             state_r, state_nxt;
  logic [W_ADR-1:0]   cnt_r, cnt_nxt;
  logic [W_IDX-1:0]   widx_r, widx_nxt;
  logic [W_COL-1:0]   col_r, col_nxt;
  logic [W_IDX-1:0]   cursor_r, cursor_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               cp_vld_r, cp_vld_nxt;
  logic [W_ADR-1:0]   cp_addr_r, cp_addr_nxt;
  logic [CELL_W-1:0]  rdata_r;

  logic               mem_we;
  logic [W_ADR-1:0]   mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [W_ADR-1:0]   mem_raddr;

  logic               stb_nxt;
  logic [W_IDX-1:0]   cur_sel;
  logic [W_IDX+IDX_W-1:0] cur_ext;
  logic [CHAR_W-1:0]  rchar_nxt;
  logic [ATTR_W-1:0]  rattr_nxt;
  logic               scr_nxt;
  logic               done_nxt;

  logic               widx_full;
  logic [W_ADR-1:0]   widx_a;
  logic [W_IDX+W_ADR-1:0] widx_ext;
  logic [W_ADR+IDX_W-1:0] head_ext;
  logic [W_ADR-1:0]   head_a;
  logic [W_COL-1:0]   col_inc;

  assign clearing  = (state_r == S_CLEAR);
  assign widx_full = (widx_r >= CELLS_I);
  assign widx_ext  = {{W_ADR{1'b0}}, widx_r};
  assign widx_a    = widx_ext[W_ADR-1:0];
  assign head_ext  = {{W_ADR{1'b0}}, head.cell_index};
  assign head_a    = head_ext[W_ADR-1:0];
  assign col_inc   = (col_r == COL_MAX) ? '0 : col_r + 1'b1;
  assign cur_ext   = {{IDX_W{1'b0}}, cur_sel};

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    widx_nxt    = widx_r;
    col_nxt     = col_r;
    cursor_nxt  = cursor_r;
    cmd_nxt     = cmd_r;
    cp_vld_nxt  = 1'b0;
    cp_addr_nxt = cp_addr_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r;
    mem_wdata   = '0;
    mem_raddr   = head_a;
    pop         = 1'b0;
    stb_nxt     = 1'b0;
    cur_sel     = cursor_r;
    rchar_nxt   = '0;
    rattr_nxt   = '0;
    scr_nxt     = 1'b0;
    done_nxt    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_A) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (head_vld) begin
          pop     = 1'b1;
          cmd_nxt = head;
          unique case (head.op)
            OP_READ: begin
              state_nxt = S_READ;
            end
            OP_READ_NONE: begin
              stb_nxt = 1'b1;
            end
            OP_NEWLINE: begin
              stb_nxt  = 1'b1;
              done_nxt = head.last;
              // saturated index stays at the end of the screen
              if (!widx_full) begin
                widx_nxt = widx_r + (COLS_I - W_IDX'(col_r));
                col_nxt  = '0;
              end
            end
            OP_PUT: begin
              if (widx_full) begin
                cnt_nxt   = '0;
                state_nxt = S_SCROLL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = widx_a;
                mem_wdata  = {attr, head.char_code};
                widx_nxt   = widx_r + 1'b1;
                cursor_nxt = widx_r + 1'b1;
                col_nxt    = col_inc;
                cur_sel    = widx_r + 1'b1;
                stb_nxt    = 1'b1;
                done_nxt   = head.last;
              end
            end
          endcase
        end
      end

      S_READ: begin
        stb_nxt   = 1'b1;
        rchar_nxt = rdata_r[CHAR_W-1:0];
        rattr_nxt = rdata_r[CELL_W-1:CHAR_W];
        state_nxt = S_IDLE;
      end

      S_SCROLL: begin
        // read one row ahead, write the word read last cycle
        mem_raddr = cnt_r + COLS_A;
        if (cp_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_addr_r;
          mem_wdata = rdata_r;
        end
        if (cnt_r == SHIFT_A) begin
          state_nxt = S_SCLR;
        end else begin
          cp_vld_nxt  = 1'b1;
          cp_addr_nxt = cnt_r;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end

      S_SCLR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_A) begin
          state_nxt = S_SPUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_SPUT: begin
        mem_we     = 1'b1;
        mem_waddr  = SHIFT_A;
        mem_wdata  = {attr, cmd_r.char_code};
        widx_nxt   = SPUT_I;
        cursor_nxt = SPUT_I;
        col_nxt    = W_COL'(1);
        cur_sel    = SPUT_I;
        stb_nxt    = 1'b1;
        scr_nxt    = 1'b1;
        done_nxt   = cmd_r.last;
        cnt_nxt    = '0;
        state_nxt  = S_IDLE;
      end

      default: begin
        cnt_nxt   = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cnt_r      <= '0;
      widx_r     <= '0;
      col_r      <= '0;
      cursor_r   <= '0;
      cp_vld_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      widx_r     <= widx_nxt;
      col_r      <= col_nxt;
      cursor_r   <= cursor_nxt;
      cp_vld_r   <= cp_vld_nxt;
      out_strobe <= stb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    cp_addr_r      <= cp_addr_nxt;
    out_cursor_pos <= cur_ext[IDX_W-1:0];
    out_read_char  <= rchar_nxt;
    out_read_attr  <= rattr_nxt;
    out_scrolled   <= scr_nxt;
    out_write_done <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

endmodule
